// ----- rtl/adsbf_pkg.sv -----
// Shared types, codes and helpers for the raw output framer.
package adsbf_pkg;

    // Output mode register codes
    localparam logic [1:0] MODE_AVR   = 2'd0;
    localparam logic [1:0] MODE_BEAST = 2'd1;
    localparam logic [1:0] MODE_NONE  = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;  // unused code, silent like MODE_NONE

    // Fixed stream bytes
    localparam logic [7:0] ESC_BYTE    = 8'h1A;
    localparam logic [7:0] TYPE_SHORT  = 8'h32;  // '2'
    localparam logic [7:0] TYPE_LONG   = 8'h33;  // '3'
    localparam logic [7:0] AVR_START   = 8'h2A;  // '*'
    localparam logic [7:0] AVR_SEMI    = 8'h3B;  // ';'
    localparam logic [7:0] AVR_NEWLINE = 8'h0A;

    // Byte counts of the staged body
    localparam int          SRC_BYTES   = 21;
    localparam int          SRC_BITS    = SRC_BYTES * 8;
    localparam logic [4:0]  SHORT_BYTES = 5'd7;
    localparam logic [4:0]  LONG_BYTES  = 5'd14;
    localparam logic [4:0]  HDR_BYTES   = 5'd7;   // timestamp and level

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_TYPE,
        ST_BODY,
        ST_SEMI,
        ST_NEWLINE
    } state_t;

    // Which byte source feeds the output register
    typedef enum logic [2:0] {
        SEL_START,
        SEL_SYNC,
        SEL_TYPE,
        SEL_BODY,
        SEL_SEMI,
        SEL_NEWLINE
    } sel_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        sel_t sel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       out_free;
        logic       body_done;
        logic [1:0] mode;
    } sts_t;

    // Upper-case hex ASCII digit
    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10)
        begin
            res = 8'h30 + {4'd0, nib};
        end
        else
        begin
            res = 8'h37 + {4'd0, nib};
        end
        return res;
    endfunction

endpackage

// ----- rtl/adsb_frame_raw_output_framer.sv -----
// Top level of the Mode S raw output framer (AVR hex and Beast binary).
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | frame_head, frame_tail, long_frame,
//           |                      | capture_time, rx_level
//  output   | out_valid / out_stall| out_byte, last_byte
//  config   | cfg_valid / cfg_ready| cfg_data (output_mode)
//
// One item at a time: an item is taken while the sequencer is idle, then its
// bytes leave one per cycle from the output register unless the output stalls:
// 17 or 31 bytes in AVR mode, 16 to 44 in Beast, none with raw output off.
// The pace is set by the single byte-wide output register the sequencer feeds.
// A stall on the output freezes the sequencer; in_stall stays high until the
// final byte of the item has entered the output register.
// Reset sets the mode to no raw output and empties the output register.
module adsb_frame_raw_output_framer
    import adsbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [55:0] frame_head,
    input  logic [55:0] frame_tail,
    input  logic        long_frame,
    input  logic [47:0] capture_time,
    input  logic [7:0]  rx_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    cmd_t cmd;
    sts_t sts;
    logic idle;

    // Mode writes are taken while no item is in work or being offered
    assign cfg_ready = idle && !in_valid;

    adsbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .idle     (idle),
        .cmd      (cmd)
    );

    adsbf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .frame_head   (frame_head),
        .frame_tail   (frame_tail),
        .long_frame   (long_frame),
        .capture_time (capture_time),
        .rx_level     (rx_level),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .last_byte    (last_byte)
    );

endmodule

// ----- rtl/adsbf_ctrl.sv -----
// Sequencing state machine for the raw output framer.
module adsbf_ctrl
    import adsbf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sts_t sts,
    output logic in_stall,
    output logic idle,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   in_accept;
    logic   emit;
    logic   active_mode;

    assign in_accept   = in_valid && (state_reg == ST_IDLE);
    assign active_mode = (sts.mode == MODE_AVR) || (sts.mode == MODE_BEAST);
    assign emit        = (state_reg != ST_IDLE) && sts.out_free;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && active_mode)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                if (emit)
                begin
                    state_next = (sts.mode == MODE_BEAST) ? ST_TYPE : ST_BODY;
                end
            end
            ST_TYPE:
            begin
                if (emit)
                begin
                    state_next = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (emit && sts.body_done)
                begin
                    state_next = (sts.mode == MODE_BEAST) ? ST_IDLE : ST_SEMI;
                end
            end
            ST_SEMI:
            begin
                if (emit)
                begin
                    state_next = ST_NEWLINE;
                end
            end
            ST_NEWLINE:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        idle     = (state_reg == ST_IDLE);
        cmd.load = in_accept;
        cmd.emit = emit;
        cmd.sel  = SEL_BODY;
        unique case (state_reg)
            ST_IDLE:    cmd.sel = SEL_BODY;
            ST_HEAD:    cmd.sel = (sts.mode == MODE_BEAST) ? SEL_SYNC : SEL_START;
            ST_TYPE:    cmd.sel = SEL_TYPE;
            ST_BODY:    cmd.sel = SEL_BODY;
            ST_SEMI:    cmd.sel = SEL_SEMI;
            ST_NEWLINE: cmd.sel = SEL_NEWLINE;
            default:    cmd.sel = SEL_BODY;
        endcase
    end

endmodule

// ----- rtl/adsbf_datapath.sv -----
// Byte staging, escape and hex logic, mode register and output register.
module adsbf_datapath
    import adsbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    input  logic [55:0] frame_head,
    input  logic [55:0] frame_tail,
    input  logic        long_frame,
    input  logic [47:0] capture_time,
    input  logic [7:0]  rx_level,
    input  logic        out_stall,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    logic [1:0]          mode_reg;
    logic [SRC_BITS-1:0] src_reg;
    logic [SRC_BITS-1:0] src_next;
    logic [4:0]          cnt_reg;
    logic [4:0]          cnt_next;
    logic                long_reg;
    logic                phase_reg;
    logic                phase_next;
    logic                dup_reg;
    logic                dup_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_byte_reg;
    logic [7:0]          out_byte_next;
    logic                last_reg;
    logic                last_next;
    logic [7:0]          cur_byte;
    logic                is_beast;
    logic                cur_esc;
    logic                body_done;
    logic [4:0]          frame_cnt;

    assign is_beast  = (mode_reg == MODE_BEAST);
    assign cur_byte  = src_reg[SRC_BITS-1 -: 8];
    assign cur_esc   = (cur_byte == ESC_BYTE);
    assign frame_cnt = long_frame ? LONG_BYTES : SHORT_BYTES;

    // Final body byte: last source byte, past its hex pair or its escape copy
    assign body_done = (cnt_reg == 5'd1) &&
                       (is_beast ? (!cur_esc || dup_reg) : phase_reg);

    // Status: output register free, body finished, current mode
    assign sts = {(!out_valid_reg || !out_stall), body_done, mode_reg};

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NONE;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Staging next values: load an item or step through the body
    always_comb
    begin
        src_next   = src_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        dup_next   = dup_reg;
        if (cmd.load)
        begin
            phase_next = 1'b0;
            dup_next   = 1'b0;
            if (is_beast)
            begin
                src_next = {capture_time, rx_level, frame_head, frame_tail};
                cnt_next = frame_cnt + HDR_BYTES;
            end
            else
            begin
                src_next = {frame_head, frame_tail, 56'd0};
                cnt_next = frame_cnt;
            end
        end
        else if (cmd.emit && (cmd.sel == SEL_BODY))
        begin
            if (is_beast)
            begin
                if (cur_esc && !dup_reg)
                begin
                    dup_next = 1'b1;
                end
                else
                begin
                    dup_next = 1'b0;
                    src_next = {src_reg[SRC_BITS-9:0], 8'd0};
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            else
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    src_next = {src_reg[SRC_BITS-9:0], 8'd0};
                    cnt_next = cnt_reg - 5'd1;
                end
            end
        end
    end

    // Byte selection into the output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            last_next      = 1'b0;
            unique case (cmd.sel)
                SEL_START:   out_byte_next = AVR_START;
                SEL_SYNC:    out_byte_next = ESC_BYTE;
                SEL_TYPE:    out_byte_next = long_reg ? TYPE_LONG : TYPE_SHORT;
                SEL_BODY:
                begin
                    if (is_beast)
                    begin
                        out_byte_next = cur_byte;
                        last_next     = body_done;
                    end
                    else
                    begin
                        out_byte_next = phase_reg ? hex_ascii(cur_byte[3:0])
                                                  : hex_ascii(cur_byte[7:4]);
                    end
                end
                SEL_SEMI:    out_byte_next = AVR_SEMI;
                SEL_NEWLINE:
                begin
                    out_byte_next = AVR_NEWLINE;
                    last_next     = 1'b1;
                end
                default:     out_byte_next = out_byte_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= 5'd0;
            phase_reg     <= 1'b0;
            dup_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            dup_reg       <= dup_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        if (cmd.load)
        begin
            long_reg <= long_frame;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

endmodule
